/* rtl/core/tds_packet_deframer_top_defines.svh */
// ----------------------------------------------------------------------------
// tds deframer assertion macros
// shared concurrent assertion forms used by the deframer top level
// ----------------------------------------------------------------------------
`ifndef TDS_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define TDS_PACKET_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TDSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tds deframer: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define TDSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tds deframer: next-cycle check failed");

`endif

/* rtl/core/tdsd_pkg.sv */
// ----------------------------------------------------------------------------
// tds deframer package
// result kinds, error codes and header constants for the deframer
// ----------------------------------------------------------------------------
package tdsd_pkg;

    // header layout
    localparam int HEADER_BYTES = 8;
    localparam logic [2:0] HDR_IDX_TYPE   = 3'd0;
    localparam logic [2:0] HDR_IDX_STATUS = 3'd1;
    localparam logic [2:0] HDR_IDX_LEN_HI = 3'd2;
    localparam logic [2:0] HDR_IDX_LEN_LO = 3'd3;
    localparam logic [2:0] HDR_IDX_LAST   = 3'(HEADER_BYTES - 1);
    localparam logic [15:0] HEADER_LEN    = 16'(HEADER_BYTES);

    // end of message flag in the status byte
    localparam logic [7:0] EOM_BIT = 8'h01;

    // max packet size after reset
    localparam logic [15:0] MAX_SIZE_RESET = 16'd4096;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_result_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TOO_LONG  = 2'd1,
        ERR_TOO_SHORT = 2'd2
    } t_error_code;

endpackage

/* rtl/core/tds_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// tds packet deframer
// strips 8-byte tds headers from a byte stream and tags each payload byte
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_data_valid / o_data_ready) takes one stream byte a beat.
//   result channel (o_res_valid / i_res_ready) gives at most one result per
//   input beat: a payload byte, an empty-packet marker or an error.
//   config channel (i_cfg_valid / o_cfg_ready) writes max_packet_size; it is
//   always ready and should be written only while the block is idle.
// Latency: a result is valid in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while i_res_ready stays high; each byte is
//   decoded combinationally into the parser state and result registers.
// Header bytes give no result; the length check on the eighth header byte
//   gives either the empty marker, an error, or nothing (payload follows).
// Stall: while a result waits and i_res_ready is low, o_data_ready is low;
//   the input is taken again in the cycle the result is taken.
// Error: the block halts and drops every later byte until reset.
// Reset (i_rst_n low, synchronous): header parser restarts, result register
//   empties, max_packet_size returns to 4096.
// ----------------------------------------------------------------------------
`include "tds_packet_deframer_top_defines.svh"

module tds_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_packet_size,
    // input byte channel
    input  logic        i_data_valid,
    output logic        o_data_ready,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_packet_status,
    output logic        o_last_in_packet,
    output logic        o_last_in_message,
    output logic [1:0]  o_error_code
);

    // parser state
    logic [15:0] r_max_size;
    logic [2:0]  r_hdr_idx,    n_hdr_idx;
    logic        r_in_payload, n_in_payload;
    logic [7:0]  r_cur_type,   n_cur_type;
    logic [7:0]  r_cur_status, n_cur_status;
    logic [7:0]  r_len_hi,     n_len_hi;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_halted,     n_halted;

    // result register
    logic                  r_res_valid;
    tdsd_pkg::t_result_kind r_kind,     n_kind;
    logic [7:0]            r_byte,     n_byte;
    logic [7:0]            r_type;
    logic [7:0]            r_status;
    logic                  r_last,     n_last;
    logic                  r_last_msg;
    tdsd_pkg::t_error_code r_err,      n_err;
    logic                  n_emit;

    logic        in_beat;
    logic [15:0] left_dec;
    logic [15:0] left_net;

    assign o_cfg_ready  = 1'b1;
    assign o_data_ready = !r_res_valid || i_res_ready;
    assign in_beat      = i_data_valid && o_data_ready;

    assign left_dec = r_bytes_left - 16'd1;
    assign left_net = r_bytes_left - tdsd_pkg::HEADER_LEN;

    // next state and result decode for one byte
    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_in_payload = r_in_payload;
        n_cur_type   = r_cur_type;
        n_cur_status = r_cur_status;
        n_len_hi     = r_len_hi;
        n_bytes_left = r_bytes_left;
        n_halted     = r_halted;
        n_emit       = 1'b0;
        n_kind       = tdsd_pkg::KIND_PAYLOAD;
        n_byte       = 8'd0;
        n_last       = 1'b0;
        n_err        = tdsd_pkg::ERR_NONE;
        if (!r_halted) begin
            if (r_in_payload) begin
                n_bytes_left = left_dec;
                n_emit       = 1'b1;
                n_byte       = i_data_byte;
                if (left_dec == 16'd0) begin
                    n_in_payload = 1'b0;
                    n_last       = 1'b1;
                end
            end else begin
                case (r_hdr_idx)
                    tdsd_pkg::HDR_IDX_TYPE:   n_cur_type   = i_data_byte;
                    tdsd_pkg::HDR_IDX_STATUS: n_cur_status = i_data_byte;
                    tdsd_pkg::HDR_IDX_LEN_HI: n_len_hi     = i_data_byte;
                    tdsd_pkg::HDR_IDX_LEN_LO: n_bytes_left = {r_len_hi, i_data_byte};
                    default: ;
                endcase
                n_hdr_idx = r_hdr_idx + 3'd1;
                // length check on the final header byte
                if (r_hdr_idx == tdsd_pkg::HDR_IDX_LAST) begin
                    if (r_bytes_left > r_max_size) begin
                        n_halted = 1'b1;
                        n_emit   = 1'b1;
                        n_kind   = tdsd_pkg::KIND_ERROR;
                        n_err    = tdsd_pkg::ERR_TOO_LONG;
                    end else if (r_bytes_left < tdsd_pkg::HEADER_LEN) begin
                        n_halted = 1'b1;
                        n_emit   = 1'b1;
                        n_kind   = tdsd_pkg::KIND_ERROR;
                        n_err    = tdsd_pkg::ERR_TOO_SHORT;
                    end else begin
                        n_bytes_left = left_net;
                        if (left_net == 16'd0) begin
                            n_emit = 1'b1;
                            n_kind = tdsd_pkg::KIND_EMPTY;
                            n_last = 1'b1;
                        end else begin
                            n_in_payload = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= tdsd_pkg::MAX_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_size <= i_cfg_max_packet_size;
        end
    end

    // parser state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= 3'd0;
            r_in_payload <= 1'b0;
            r_cur_type   <= 8'd0;
            r_cur_status <= 8'd0;
            r_len_hi     <= 8'd0;
            r_bytes_left <= 16'd0;
            r_halted     <= 1'b0;
        end else if (in_beat) begin
            r_hdr_idx    <= n_hdr_idx;
            r_in_payload <= n_in_payload;
            r_cur_type   <= n_cur_type;
            r_cur_status <= n_cur_status;
            r_len_hi     <= n_len_hi;
            r_bytes_left <= n_bytes_left;
            r_halted     <= n_halted;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (in_beat && n_emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_beat && n_emit) begin
            r_kind     <= n_kind;
            r_byte     <= n_byte;
            r_type     <= r_cur_type;
            r_status   <= r_cur_status;
            r_last     <= n_last;
            r_last_msg <= n_last && ((r_cur_status & tdsd_pkg::EOM_BIT) != 8'd0);
            r_err      <= n_err;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_result_kind     = r_kind;
    assign o_payload_byte    = r_byte;
    assign o_msg_type        = r_type;
    assign o_packet_status   = r_status;
    assign o_last_in_packet  = r_last;
    assign o_last_in_message = r_last_msg;
    assign o_error_code      = r_err;

    // checks
    `TDSD_ASSERT_NOW(a_err_result_form, i_clk, i_rst_n,
        r_res_valid && (r_kind == tdsd_pkg::KIND_ERROR),
        !r_last && (r_err != tdsd_pkg::ERR_NONE) && r_halted)
    `TDSD_ASSERT_NOW(a_eom_needs_last, i_clk, i_rst_n,
        r_res_valid && r_last_msg, r_last && r_status[0])
    `TDSD_ASSERT_NOW(a_payload_count_live, i_clk, i_rst_n,
        r_in_payload, r_bytes_left != 16'd0)
    `TDSD_ASSERT_NEXT(a_halted_silent, i_clk, i_rst_n,
        r_halted && !r_res_valid, !r_res_valid)

endmodule
